>>> design/hcc_pkg.sv
package hcc_pkg;

   localparam int MAP_DEPTH_DEFAULT = 8192;
   localparam logic [13:0] MEM_SIZE_RESET = 14'd8192;

   // two-bit use marks, saturating at MARK_MULTI
   localparam logic [1:0] MARK_EMPTY = 2'd0;
   localparam logic [1:0] MARK_ONCE  = 2'd1;
   localparam logic [1:0] MARK_MULTI = 2'd2;

   localparam logic [7:0] REC_DATA = 8'd0;

   typedef struct packed {
      logic [7:0]  record_type;
      logic [15:0] record_address;
      logic [7:0]  record_length;
   } req_type;

   typedef struct packed {
      logic [13:0] used_count;
      logic [13:0] overlap_count;
      logic [16:0] top_address;
      logic        overflow_seen;
      logic        record_overlapped;
      logic        record_overflowed;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

endpackage

>>> design/hex_record_coverage_checker_unit.sv
// Load-map coverage checker, one request per parsed load record; one map
// read-modify-write per byte that lands in memory. After the walk and its last
// write-back, the finish state raises the registered result strobe.
// Busy drops with the strobe; next request at the edge ending it.
// Reset (synchronous): totals clear and a sweep zeroes the use map one entry a
// cycle, MAP_DEPTH entries (8192 by default) with busy high; the receiver cannot stall.
module hex_record_coverage_checker_unit #(
   parameter int MAP_DEPTH = hcc_pkg::MAP_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hcc_pkg::req_type req_data,
   output logic             rsp_valid,
   output hcc_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [13:0]      csr_wr_data
);

   localparam int AW = $clog2(MAP_DEPTH);
   localparam logic [AW-1:0] LAST_ENTRY = AW'(MAP_DEPTH - 1);
   localparam logic [16:0] DEPTH_LIMIT = 17'(MAP_DEPTH);

   hcc_pkg::state_type state_ff, state_in;

   // record being walked
   logic [15:0]   addr_ff, addr_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    idx_ff, idx_in;

   // clearing sweep
   logic [AW-1:0] clear_ff, clear_in;

   // read issued last cycle, its mark arrives now
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;

   // running totals and per-record flags
   logic [13:0]   used_ff, used_in;
   logic [13:0]   ovl_ff, ovl_in;
   logic [16:0]   top_ff, top_in;
   logic          ovf_ff, ovf_in;
   logic          rec_ovl_ff, rec_ovl_in;
   logic          rec_ovf_ff, rec_ovf_in;

   logic [13:0]   mem_size_ff, mem_size_in;

   logic             rsp_valid_ff, rsp_valid_in;
   hcc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // map port
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [1:0]    ram_wr_data;
   logic [1:0]    ram_rd_data;

   logic [16:0]   limit;
   logic [16:0]   cur_addr;
   logic          in_range;

   // limit saturates at the map depth
   always_comb begin
      if ({3'b000, mem_size_ff} > DEPTH_LIMIT) begin
         limit = DEPTH_LIMIT;
      end else begin
         limit = {3'b000, mem_size_ff};
      end
   end

   assign cur_addr = {1'b0, addr_ff} + {9'd0, idx_ff};
   assign in_range = cur_addr < limit;

   hcc_ram #(
      .WIDTH (2),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (cur_addr[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      clear_in     = clear_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      used_in      = used_ff;
      ovl_in       = ovl_ff;
      top_in       = top_ff;
      ovf_in       = ovf_ff;
      rec_ovl_in   = rec_ovl_ff;
      rec_ovf_in   = rec_ovf_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pend_addr_ff;
      ram_wr_data  = hcc_pkg::MARK_EMPTY;

      mem_size_in  = csr_wr_en ? csr_wr_data : mem_size_ff;

      // write-back stage: mark read last cycle; addresses within a record
      // never repeat, so it never races the read issued alongside it
      if (pend_ff) begin
         ram_wr_en = 1'b1;
         unique case (ram_rd_data)
            hcc_pkg::MARK_EMPTY: begin
               ram_wr_data = hcc_pkg::MARK_ONCE;
               used_in     = used_ff + 14'd1;
            end
            hcc_pkg::MARK_ONCE: begin
               ram_wr_data = hcc_pkg::MARK_MULTI;
               ovl_in      = ovl_ff + 14'd1;
               rec_ovl_in  = 1'b1;
            end
            default: begin
               ram_wr_data = hcc_pkg::MARK_MULTI;
               rec_ovl_in  = 1'b1;
            end
         endcase
      end

      unique case (state_ff)
         hcc_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clear_ff;
            ram_wr_data = hcc_pkg::MARK_EMPTY;
            clear_in    = clear_ff + AW'(1);
            if (clear_ff == LAST_ENTRY) begin
               state_in = hcc_pkg::ST_IDLE;
            end
         end
         hcc_pkg::ST_IDLE: begin
            if (start) begin
               addr_in    = req_data.record_address;
               // non-data records walk nothing
               len_in     = (req_data.record_type == hcc_pkg::REC_DATA) ?
                            req_data.record_length : 8'd0;
               idx_in     = 8'd0;
               rec_ovl_in = 1'b0;
               rec_ovf_in = 1'b0;
               state_in   = hcc_pkg::ST_WALK;
            end
         end
         hcc_pkg::ST_WALK: begin
            if (idx_ff != len_ff) begin
               idx_in = idx_ff + 8'd1;
               if (cur_addr > top_ff) begin
                  top_in = cur_addr;
               end
               if (in_range) begin
                  pend_in      = 1'b1;
                  pend_addr_in = cur_addr[AW-1:0];
               end else begin
                  rec_ovf_in = 1'b1;
                  ovf_in     = 1'b1;
               end
            end else if (!pend_ff) begin
               state_in = hcc_pkg::ST_FINISH;
            end
         end
         hcc_pkg::ST_FINISH: begin
            rsp_valid_in                  = 1'b1;
            rsp_data_in.used_count        = used_ff;
            rsp_data_in.overlap_count     = ovl_ff;
            rsp_data_in.top_address       = top_ff;
            rsp_data_in.overflow_seen     = ovf_ff;
            rsp_data_in.record_overlapped = rec_ovl_ff;
            rsp_data_in.record_overflowed = rec_ovf_ff;
            state_in                      = hcc_pkg::ST_IDLE;
         end
         default: begin
            state_in = hcc_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hcc_pkg::ST_CLEAR;
         len_ff       <= 8'd0;
         idx_ff       <= 8'd0;
         clear_ff     <= '0;
         pend_ff      <= 1'b0;
         used_ff      <= 14'd0;
         ovl_ff       <= 14'd0;
         top_ff       <= 17'd0;
         ovf_ff       <= 1'b0;
         rec_ovl_ff   <= 1'b0;
         rec_ovf_ff   <= 1'b0;
         mem_size_ff  <= hcc_pkg::MEM_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         clear_ff     <= clear_in;
         pend_ff      <= pend_in;
         used_ff      <= used_in;
         ovl_ff       <= ovl_in;
         top_ff       <= top_in;
         ovf_ff       <= ovf_in;
         rec_ovl_ff   <= rec_ovl_in;
         rec_ovf_ff   <= rec_ovf_in;
         mem_size_ff  <= mem_size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      pend_addr_ff <= pend_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign busy      = (state_ff != hcc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> design/hcc_ram.sv
module hcc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = hcc_pkg::MAP_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/hcc_checker.sv
module hcc_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input hcc_pkg::rsp_type rsp_data
);

   // an accepted request holds the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_overlap_le_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.overlap_count <= rsp_data.used_count)
      else $error("overlap count above used count");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.record_overflowed |-> rsp_data.overflow_seen)
      else $error("record overflow without overflow flag");

endmodule

bind hex_record_coverage_checker_unit hcc_checker u_hcc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
